### rtl/core/cnng_pkg.sv
// Shared types, constants and helpers for the CANopen node guard block.
`default_nettype none

package cnng_pkg;

   // Field widths.
   localparam int unsigned IdWidth     = 11;
   localparam int unsigned NodeWidth   = 7;
   localparam int unsigned LenWidth    = 4;
   localparam int unsigned ByteWidth   = 8;
   localparam int unsigned CodeWidth   = 7;

   // CANopen identifier bases and the NMT broadcast identifier.
   localparam logic [IdWidth-1:0]   GuardBase  = 11'h700;
   localparam logic [IdWidth-1:0]   Pdo1Base   = 11'h200;
   localparam logic [IdWidth-1:0]   NmtId      = 11'h000;
   localparam logic [NodeWidth-1:0] NodeIdRst  = 7'd1;
   localparam logic [NodeWidth-1:0] NmtAllNode = 7'd0;

   // NMT command codes.
   localparam logic [ByteWidth-1:0] NmtCmdStart = 8'h01;
   localparam logic [ByteWidth-1:0] NmtCmdStop  = 8'h02;
   localparam logic [ByteWidth-1:0] NmtCmdPreop = 8'h80;

   // Guard reply state codes.
   localparam logic [CodeWidth-1:0] CodeStopped = 7'h04;
   localparam logic [CodeWidth-1:0] CodeOper    = 7'h05;
   localparam logic [CodeWidth-1:0] CodePreop   = 7'h7F;

   // Node state, encoded as reported on the result channel.
   typedef enum logic [1:0] {
      MODE_STOPPED = 2'd0,
      MODE_PREOP   = 2'd1,
      MODE_OPER    = 2'd2
   } mode_type;

   // Frame classification handed from the decoder to the state logic.
   typedef struct packed {
      logic guard_req;   // remote frame at the guard identifier
      logic nmt_req;     // NMT frame addressed to this node or to all
      logic pdo_req;     // data frame at the receive-PDO1 identifier
      logic mask_load;   // PDO frame carries a new relay mask
   } frame_class_type;

   // Guard reply state code for a node state.
   function automatic logic [CodeWidth-1:0] state_code(input mode_type m);
      logic [CodeWidth-1:0] code;
      code = CodePreop;
      if (m == MODE_STOPPED) begin
         code = CodeStopped;
      end else if (m == MODE_OPER) begin
         code = CodeOper;
      end
      return code;
   endfunction

endpackage

`default_nettype wire

### rtl/core/canopen_node_nmt_pdo_guard.sv
// CANopen NMT slave with receive PDO1 relay control and node guarding replies.
// A request passes through the input register and then the result register before it reaches the rsp port.
// Throughput: one frame per cycle while rsp_stall is low; the input and result registers form a pipeline.
// rsp_stall holds both stages; req_stall rises only when the input stage is full.
// Synchronous reset: operational, relay mask 0xFF, relays off, toggle 0, node 1.
`default_nettype none

module canopen_node_nmt_pdo_guard
   import cnng_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,

   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic [IdWidth-1:0]   req_frame_id,
   input  wire logic                 req_is_remote,
   input  wire logic [LenWidth-1:0]  req_length,
   input  wire logic [ByteWidth-1:0] req_byte0,
   input  wire logic [ByteWidth-1:0] req_byte1,

   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [ByteWidth-1:0]      rsp_relay_state,
   output logic [1:0]                rsp_node_state,
   output logic                      rsp_reply_valid,
   output logic [IdWidth-1:0]        rsp_reply_id,
   output logic [ByteWidth-1:0]      rsp_reply_byte,

   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [NodeWidth-1:0] csr_data
);

   logic [NodeWidth-1:0] node_id_ff;

   logic                 in_valid_ff;
   logic                 in_valid_in;
   logic [IdWidth-1:0]   frame_id_ff;
   logic                 is_remote_ff;
   logic [LenWidth-1:0]  length_ff;
   logic [ByteWidth-1:0] byte0_ff;
   logic [ByteWidth-1:0] byte1_ff;

   logic                 out_valid_ff;
   logic                 out_valid_in;
   logic [ByteWidth-1:0] relay_state_ff;
   logic [1:0]           node_state_ff;
   logic                 reply_valid_ff;
   logic [IdWidth-1:0]   reply_id_ff;
   logic [ByteWidth-1:0] reply_byte_ff;

   logic                 advance;
   logic                 req_fire;
   logic                 in_fire;
   frame_class_type      frame_class;
   mode_type             mode_next;
   logic [ByteWidth-1:0] relays_next;
   logic [ByteWidth-1:0] reply_byte_next;
   logic [IdWidth-1:0]   guard_id;

   // Pipeline control: the result register frees when empty or being taken.
   assign advance   = !out_valid_ff || !rsp_stall;
   assign in_fire   = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;
   assign req_fire  = req_valid && !req_stall;

   assign in_valid_in  = req_fire || (in_valid_ff && !advance);
   assign out_valid_in = in_fire  || (out_valid_ff && rsp_stall);

   // Node number register; writes must arrive only while the block is idle, which the block does not enforce.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         node_id_ff <= NodeIdRst;
      end else if (csr_valid && csr_ready) begin
         node_id_ff <= csr_data;
      end
   end

   // Valid flags for both stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Input register captures each accepted transaction.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         frame_id_ff  <= req_frame_id;
         is_remote_ff <= req_is_remote;
         length_ff    <= req_length;
         byte0_ff     <= req_byte0;
         byte1_ff     <= req_byte1;
      end
   end

   cnng_decode u_decode (
      .frame_id    (frame_id_ff),
      .is_remote   (is_remote_ff),
      .length      (length_ff),
      .byte0       (byte0_ff),
      .node_id     (node_id_ff),
      .frame_class (frame_class)
   );

   cnng_state u_state (
      .clock       (clock),
      .reset       (reset),
      .update      (in_fire),
      .frame_class (frame_class),
      .byte0       (byte0_ff),
      .byte1       (byte1_ff),
      .mode_next   (mode_next),
      .relays_next (relays_next),
      .reply_byte  (reply_byte_next)
   );

   assign guard_id = GuardBase | IdWidth'(node_id_ff);

   // Result register loads as the frame leaves the input stage.
   always_ff @(posedge clock) begin
      if (in_fire) begin
         relay_state_ff <= relays_next;
         node_state_ff  <= mode_next;
         reply_valid_ff <= frame_class.guard_req;
         reply_id_ff    <= frame_class.guard_req ? guard_id : '0;
         reply_byte_ff  <= reply_byte_next;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_relay_state = relay_state_ff;
   assign rsp_node_state  = node_state_ff;
   assign rsp_reply_valid = reply_valid_ff;
   assign rsp_reply_id    = reply_id_ff;
   assign rsp_reply_byte  = reply_byte_ff;

   // The input stage only pushes back when it holds a transaction.
   assert property (@(posedge clock) disable iff (reset) req_stall |-> in_valid_ff)
      else $error("input stall raised with an empty input stage");

   // A guard reply always carries the guard identifier base.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_reply_valid) |-> (rsp_reply_id[IdWidth-1:NodeWidth] == 4'hE))
      else $error("guard reply identifier outside the guard range");

   // Without a reply the reply fields read as zero.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_reply_valid) |-> (rsp_reply_id == '0 && rsp_reply_byte == '0))
      else $error("reply fields set without a guard reply");

   // A guard reply carries one of the three state codes.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_reply_valid) |->
         (rsp_reply_byte[CodeWidth-1:0] == CodeStopped ||
          rsp_reply_byte[CodeWidth-1:0] == CodeOper ||
          rsp_reply_byte[CodeWidth-1:0] == CodePreop))
      else $error("guard reply with an unknown state code");

   // A stalled result keeps its relay levels.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> $stable(rsp_relay_state))
      else $error("relay result changed under stall");

endmodule

`default_nettype wire

### rtl/core/cnng_decode.sv
// Frame classifier: matches the identifier, frame type, length and NMT address byte of one frame.
`default_nettype none

module cnng_decode
   import cnng_pkg::*;
(
   input  wire logic [IdWidth-1:0]   frame_id,
   input  wire logic                 is_remote,
   input  wire logic [LenWidth-1:0]  length,
   input  wire logic [ByteWidth-1:0] byte0,
   input  wire logic [NodeWidth-1:0] node_id,
   output frame_class_type           frame_class
);

   logic [IdWidth-1:0] guard_id;
   logic [IdWidth-1:0] pdo_id;
   logic               len_nonzero;
   logic               len_ge2;
   logic               addressed;

   // Node-specific identifiers; the node number never carries into the base.
   assign guard_id = GuardBase | IdWidth'(node_id);
   assign pdo_id   = Pdo1Base  | IdWidth'(node_id);

   // Length codes above eight count as eight, which changes neither test.
   assign len_nonzero = (length != '0);
   assign len_ge2     = (length >= LenWidth'(2));

   // An NMT frame is for this node when byte 0 is zero or the node number.
   assign addressed = (byte0 == ByteWidth'(NmtAllNode)) || (byte0 == ByteWidth'(node_id));

   // Classify the frame.
   always_comb begin
      frame_class.guard_req = is_remote && (frame_id == guard_id);
      frame_class.nmt_req   = !is_remote && len_ge2 && (frame_id == NmtId) && addressed;
      frame_class.pdo_req   = !is_remote && len_nonzero && (frame_id == pdo_id)
                              && (frame_id != NmtId);
      frame_class.mask_load = len_ge2;
   end

endmodule

`default_nettype wire

### rtl/core/cnng_state.sv
// Node state, relay mask, relay levels and guard toggle with their update logic.
`default_nettype none

module cnng_state
   import cnng_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 update,
   input  wire frame_class_type      frame_class,
   input  wire logic [ByteWidth-1:0] byte0,
   input  wire logic [ByteWidth-1:0] byte1,
   output mode_type                  mode_next,
   output logic [ByteWidth-1:0]      relays_next,
   output logic [ByteWidth-1:0]      reply_byte
);

   mode_type             mode_ff;
   mode_type             mode_in;
   logic [ByteWidth-1:0] mask_ff;
   logic [ByteWidth-1:0] mask_in;
   logic [ByteWidth-1:0] relays_ff;
   logic [ByteWidth-1:0] relays_in;
   logic                 toggle_ff;
   logic                 toggle_in;

   // NMT command decode.
   always_comb begin
      mode_in = mode_ff;
      if (frame_class.nmt_req) begin
         unique case (byte1)
            NmtCmdStart: mode_in = MODE_OPER;
            NmtCmdStop:  mode_in = MODE_STOPPED;
            NmtCmdPreop: mode_in = MODE_PREOP;
            default:     mode_in = mode_ff;
         endcase
      end
   end

   // Receive PDO in operational mode: optional new mask, then masked relay update.
   always_comb begin
      mask_in   = mask_ff;
      relays_in = relays_ff;
      if (frame_class.pdo_req && (mode_ff == MODE_OPER)) begin
         if (frame_class.mask_load) begin
            mask_in = byte1;
         end
         relays_in = (relays_ff & ~mask_in) | (byte0 & mask_in);
      end
   end

   // Guard reply uses the toggle and state from before this frame.
   assign toggle_in  = toggle_ff ^ frame_class.guard_req;
   assign reply_byte = frame_class.guard_req ? {toggle_ff, state_code(mode_ff)} : '0;

   assign mode_next   = mode_in;
   assign relays_next = relays_in;

   // State registers advance once per transaction.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_OPER;
         mask_ff   <= '1;
         relays_ff <= '0;
         toggle_ff <= 1'b0;
      end else if (update) begin
         mode_ff   <= mode_in;
         mask_ff   <= mask_in;
         relays_ff <= relays_in;
         toggle_ff <= toggle_in;
      end
   end

endmodule

`default_nettype wire
